FILE: hdl/kmfs_pkg.sv
// Shared types and constants for the keyboard mode flag stack.
`timescale 1ns / 1ps
`default_nettype none
package kmfs_pkg;

  localparam int FLAG_W      = 5;
  localparam int POP_COUNT_W = 8;
  localparam int DEPTH_OUT_W = 4;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_SET   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SM_KEEP    = 2'd0,
    SM_REPLACE = 2'd1,
    SM_OR      = 2'd2,
    SM_CLEAR   = 2'd3
  } set_mode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [FLAG_W-1:0]      requested_flags;
    set_mode_t              set_mode;
    logic [POP_COUNT_W-1:0] pop_count;
  } cmd_t;

  typedef struct packed {
    logic [FLAG_W-1:0]      current_flags;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/kmfs_core.sv
// Flag register and bounded save stack, updated by one command per enabled cycle.
`timescale 1ns / 1ps
`default_nettype none
module kmfs_core #(
  parameter int STACK_DEPTH = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              en,
  input  wire kmfs_pkg::cmd_t              cmd,
  input  wire  [kmfs_pkg::FLAG_W-1:0]      supported_mask,
  output kmfs_pkg::result_t                result,
  output logic [$clog2(STACK_DEPTH+1)-1:0] count
);
  import kmfs_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [POP_COUNT_W-1:0] DEPTH_C = POP_COUNT_W'(STACK_DEPTH);

  logic [FLAG_W-1:0]      flags;
  logic [FLAG_W-1:0]      flags_next;
  logic [CW-1:0]          count_next;
  logic [FLAG_W-1:0]      saved [STACK_DEPTH];
  logic [FLAG_W-1:0]      masked_req;
  logic [POP_COUNT_W-1:0] pop_n;
  logic [CW-1:0]          pop_left;
  logic                   full;

  assign masked_req = cmd.requested_flags & supported_mask;
  assign full       = (count == CW'(STACK_DEPTH));

  // A count of zero pops one entry; anything above the depth pops the depth.
  always_comb begin
    if (cmd.pop_count == '0) begin
      pop_n = POP_COUNT_W'(1);
    end else if (cmd.pop_count > DEPTH_C) begin
      pop_n = DEPTH_C;
    end else begin
      pop_n = cmd.pop_count;
    end
  end

  assign pop_left = count - CW'(pop_n);

  always_comb begin
    flags_next = flags;
    count_next = count;
    case (cmd.opcode)
      OP_RESET: begin
        flags_next = '0;
        count_next = '0;
      end
      OP_PUSH: begin
        flags_next = masked_req;
        count_next = full ? count : count + CW'(1);
      end
      OP_POP: begin
        if (pop_n > POP_COUNT_W'(count)) begin
          flags_next = '0;
          count_next = '0;
        end else begin
          flags_next = saved[pop_left[IW-1:0]];
          count_next = pop_left;
        end
      end
      OP_SET: begin
        case (cmd.set_mode)
          SM_REPLACE: flags_next = masked_req;
          SM_OR:      flags_next = flags | masked_req;
          SM_CLEAR:   flags_next = flags & ~masked_req;
          default:    flags_next = flags;
        endcase
      end
      default: begin
        flags_next = flags;
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      count <= '0;
    end else if (en) begin
      flags <= flags_next;
      count <= count_next;
    end
  end

  // On a push into a full stack the oldest entry falls out of the bottom.
  always_ff @(posedge clk) begin
    if (en && cmd.opcode == OP_PUSH) begin
      if (full) begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          saved[i] <= saved[i+1];
        end
        saved[STACK_DEPTH-1] <= flags;
      end else begin
        saved[count[IW-1:0]] <= flags;
      end
    end
  end

  assign result.current_flags = flags_next;
  assign result.stack_depth   = DEPTH_OUT_W'(count_next);

endmodule
`default_nettype wire

FILE: hdl/keyboard_mode_flag_stack_top.sv
// Top level of the keyboard mode flag stack: stream ports, config register, pipeline.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tuser opcode, s_tdata command fields
// m_*       out        m_tvalid / m_tready  m_tdata current flags and stack depth
// cfg_*     in         cfg_valid/cfg_ready  cfg_data supported mask
//
// Each command passes an input register and then a result register, so a result is
// offered on m_tvalid once the result register loads it. One command is taken every
// cycle unless m_tready stalls. A step updates the flag register and save stack together.
// Reset (rst, synchronous) empties the stack, clears the flags and the pipeline,
// and sets the supported mask to all ones. A stall on m_tready holds the result
// register; the input register takes one more command only while empty, then s_tready drops.
module keyboard_mode_flag_stack_top #(
  parameter int STACK_DEPTH = 8
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // requested_flags[4:0], set_mode[6:5], pop_count[14:7], zero[15]
  input  wire  [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata,   // current_flags[4:0], stack_depth[8:5], zero[15:9]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [4:0]  cfg_data   // supported_mask[4:0]
);
  import kmfs_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [FLAG_W-1:0] supported_mask;
  logic              in_valid;
  cmd_t              in_cmd;
  logic              advance;
  logic              step;
  result_t           core_result;
  result_t           out_result;
  logic [CW-1:0]     core_count;

  // The result register frees up when empty or when its transfer completes.
  assign advance   = !m_tvalid || m_tready;
  assign step      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      supported_mask <= '1;
    end else if (cfg_valid) begin
      supported_mask <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd.opcode          <= opcode_t'(s_tuser);
      in_cmd.requested_flags <= s_tdata[4:0];
      in_cmd.set_mode        <= set_mode_t'(s_tdata[6:5]);
      in_cmd.pop_count       <= s_tdata[14:7];
    end
  end

  kmfs_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .en             (step),
    .cmd            (in_cmd),
    .supported_mask (supported_mask),
    .result         (core_result),
    .count          (core_count)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign m_tdata = {7'd0, out_result.stack_depth, out_result.current_flags};

`ifndef ASSERT_OFF
  // The saved count never goes past the stack depth.
  assert property (@(posedge clk) disable iff (rst) core_count <= CW'(STACK_DEPTH))
    else $error("saved count exceeds stack depth");

  // A reset command always comes out with no flags and an empty stack.
  assert property (@(posedge clk) disable iff (rst)
    step && in_cmd.opcode == OP_RESET |=> m_tvalid && m_tdata[8:0] == 9'd0)
    else $error("reset command left flags or stack");

  // A push loads only flags that the supported mask allows.
  assert property (@(posedge clk) disable iff (rst)
    step && in_cmd.opcode == OP_PUSH |=> (m_tdata[4:0] & ~$past(supported_mask)) == '0)
    else $error("push loaded unsupported flags");

  // A held command in the input register stays while the result side is stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_cmd))
    else $error("stalled command lost from input register");
`endif

endmodule
`default_nettype wire
